@@ hdl/grr_pkg.sv @@
// Shared types and constants for the group reverse reorder block.
`timescale 1ns / 1ps

package grr_pkg;

	// Field widths fixed by the stream format
	localparam int VALUE_W = 32;
	localparam int GSIZE_W = 5;

	// Default depth of the cell chain
	localparam int MAX_GROUP_DEF = 16;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN_REV,
		ST_DRAIN_FWD
	} grr_state_t;

	// Per-cycle commands broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

@@ hdl/grr_cell.sv @@
// One storage cell of the value chain: loads from its lower neighbour on push,
// from its upper neighbour on pop.
`timescale 1ns / 1ps

module grr_cell (
	input  logic                               clk,
	input  grr_pkg::cell_ctrl_t                ctrl,
	input  logic signed [grr_pkg::VALUE_W-1:0] lower,
	input  logic signed [grr_pkg::VALUE_W-1:0] upper,
	output logic signed [grr_pkg::VALUE_W-1:0] data
);
	import grr_pkg::*;

	logic signed [VALUE_W-1:0] data_q;

	// Shift the chain up on push, down on pop, else hold
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= lower;
		end else if (ctrl.pop) begin
			data_q <= upper;
		end
	end

	assign data = data_q;

endmodule

@@ hdl/group_reverse_reorder.sv @@
// Top level: a cell chain replays full groups reversed, a partial last group in order.
//
//  port group   | dir | tdata / tuser contents (low bit up)     | tlast
//  s_*          | in  | tdata: value[31:0]                      | last of sequence
//  m_*          | out | tdata: value_res[31:0]; tuser: seq_end  | run_end
//  cfg_*        | in  | wdata: group_size[4:0], written on cfg_we| -
//
// An item that holds its value leaves s_tready high for the next one. An item
// that closes a group, or ends the sequence, is followed by a drain of every
// held value through the output register; s_tready stays low until then.
// Reset (arst_n low) empties the chain and sets group_size to 1.
// A stalled m_tready holds the output register and pauses the drain.
`timescale 1ns / 1ps

module group_reverse_reorder #(
	parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [grr_pkg::GSIZE_W-1:0]        cfg_wdata,   // group_size
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic signed [grr_pkg::VALUE_W-1:0] s_tdata,     // value
	input  logic                               s_tlast,
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic signed [grr_pkg::VALUE_W-1:0] m_tdata,     // value_res
	output logic                               m_tlast,
	output logic                               m_tuser      // seq_end
);
	import grr_pkg::*;

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int KW = (CW > GSIZE_W) ? CW : GSIZE_W;

	grr_state_t state_q, state_d;
	logic [GSIZE_W-1:0]        gsize_q;
	logic [CW-1:0]             count_q;
	logic                      last_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_run_end_q;
	logic                      out_seq_end_q;

	cell_ctrl_t                ctrl;
	logic signed [VALUE_W-1:0] cells [MAX_GROUP];
	logic                      accept;
	logic                      drain;
	logic                      out_free;
	logic [CW-1:0]             fill_next;
	logic [KW-1:0]             k_eff;
	logic                      group_full;
	logic [IW-1:0]             fwd_idx;
	logic signed [VALUE_W-1:0] drain_value;
	logic                      drain_run_end;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q <= GSIZE_W'(1);
		end else if (cfg_we) begin
			gsize_q <= cfg_wdata;
		end
	end

	// Clamp group size to the range 1 .. MAX_GROUP
	always_comb begin
		if (gsize_q == '0) begin
			k_eff = KW'(1);
		end else if (KW'(gsize_q) > KW'(MAX_GROUP)) begin
			k_eff = KW'(MAX_GROUP);
		end else begin
			k_eff = KW'(gsize_q);
		end
	end

	assign fill_next  = count_q + CW'(1);
	assign group_full = KW'(fill_next) >= k_eff;
	assign out_free   = !out_valid_q || m_tready;
	assign accept     = s_tvalid && s_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (group_full) begin
						state_d = ST_DRAIN_REV;
					end else if (s_tlast) begin
						state_d = ST_DRAIN_FWD;
					end
				end
			end
			ST_DRAIN_REV, ST_DRAIN_FWD: begin
				if (drain && count_q == CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and chain commands
	always_comb begin
		s_tready  = 1'b0;
		drain     = 1'b0;
		ctrl.pop  = 1'b0;
		case (state_q)
			ST_IDLE:      s_tready = 1'b1;
			ST_DRAIN_REV: begin
				drain    = out_free;
				ctrl.pop = out_free;
			end
			ST_DRAIN_FWD: drain = out_free;
			default:      s_tready = 1'b0;
		endcase
		ctrl.push = accept;
	end

	// Cell chain: newest value in cell 0, oldest in the highest filled cell
	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		logic signed [VALUE_W-1:0] lower_d;
		logic signed [VALUE_W-1:0] upper_d;
		if (i == 0) begin : g_first
			assign lower_d = s_tdata;
		end else begin : g_mid
			assign lower_d = cells[i-1];
		end
		if (i == MAX_GROUP - 1) begin : g_top
			assign upper_d = cells[i];
		end else begin : g_below
			assign upper_d = cells[i+1];
		end
		grr_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.lower (lower_d),
			.upper (upper_d),
			.data  (cells[i])
		);
	end

	// Select the next result: reversed from the bottom, in order from the highest filled cell
	assign fwd_idx       = IW'(count_q - CW'(1));
	assign drain_value   = (state_q == ST_DRAIN_REV) ? cells[0] : cells[fwd_idx];
	assign drain_run_end = (count_q == CW'(1));

	// Sequencer state, fill count and end-of-sequence flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= fill_next;
				last_q  <= s_tlast;
			end else if (drain) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (drain) begin
			out_value_q   <= drain_value;
			out_run_end_q <= drain_run_end;
			out_seq_end_q <= drain_run_end && last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tlast  = out_run_end_q;
	assign m_tuser  = out_seq_end_q;

endmodule
